// File: design/fpp_pkg.sv
// Shared types, constants and character decode functions for the FEN parser.
package fpp_pkg;

  localparam int unsigned COUNTER_WIDTH = 16;
  localparam int unsigned BOARD_DIM     = 8;
  localparam int unsigned CNT_OUT_W     = 16;
  localparam int unsigned QDEPTH        = 2;
  localparam int unsigned QAW           = $clog2(QDEPTH);

  localparam logic [7:0] CH_SLASH = 8'h2F;
  localparam logic [7:0] CH_DASH  = 8'h2D;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_THREE = 8'h33;
  localparam logic [7:0] CH_SIX   = 8'h36;
  localparam logic [7:0] CH_LC_A  = 8'h61;
  localparam logic [7:0] CH_LC_H  = 8'h68;
  localparam logic [7:0] CH_LC_W  = 8'h77;
  localparam logic [7:0] CH_LC_B  = 8'h62;

  localparam logic [3:0] CASTLE_WK = 4'b0001;
  localparam logic [3:0] CASTLE_WQ = 4'b0010;
  localparam logic [3:0] CASTLE_BK = 4'b0100;
  localparam logic [3:0] CASTLE_BQ = 4'b1000;

  localparam logic [3:0] TEN = 4'd10;

  typedef enum logic [10:0] {
    PH_BOARD      = 11'b000_0000_0001,
    PH_SIDE       = 11'b000_0000_0010,
    PH_SIDE_SP    = 11'b000_0000_0100,
    PH_CAST_FIRST = 11'b000_0000_1000,
    PH_CAST_MORE  = 11'b000_0001_0000,
    PH_CAST_SP    = 11'b000_0010_0000,
    PH_EP_FIRST   = 11'b000_0100_0000,
    PH_EP_RANK    = 11'b000_1000_0000,
    PH_EP_SP      = 11'b001_0000_0000,
    PH_HALF       = 11'b010_0000_0000,
    PH_FULL       = 11'b100_0000_0000
  } fpp_phase_e;

  // Classified character word passed from front to back.
  typedef struct packed {
    logic       last;
    logic       is_digit;
    logic [3:0] digit;
    logic       is_slash;
    logic       is_space;
    logic       is_dash;
    logic       is_piece;
    logic [3:0] piece;
    logic [3:0] castle;
    logic       is_file;
    logic [2:0] file;
    logic       is_r3;
    logic       is_r6;
    logic       is_w;
    logic       is_b;
  } fpp_cls_t;

  typedef struct packed {
    logic                 place_valid;
    logic [5:0]           square;
    logic [3:0]           piece;
    logic                 done_res;
    logic                 error;
    logic                 turn;
    logic [3:0]           castle_rights;
    logic                 ep_present;
    logic [5:0]           ep_square;
    logic [CNT_OUT_W-1:0] halfmove_count;
    logic [CNT_OUT_W-1:0] fullmove_count;
  } fpp_res_t;

  // Piece letter to code; bit 4 flags a hit.
  function automatic logic [4:0] piece_lookup(input logic [7:0] c);
    logic [4:0] r;
    case (c)
      8'h50:   r = {1'b1, 4'd0};
      8'h4E:   r = {1'b1, 4'd1};
      8'h42:   r = {1'b1, 4'd2};
      8'h52:   r = {1'b1, 4'd3};
      8'h51:   r = {1'b1, 4'd4};
      8'h4B:   r = {1'b1, 4'd5};
      8'h70:   r = {1'b1, 4'd6};
      8'h6E:   r = {1'b1, 4'd7};
      8'h62:   r = {1'b1, 4'd8};
      8'h72:   r = {1'b1, 4'd9};
      8'h71:   r = {1'b1, 4'd10};
      8'h6B:   r = {1'b1, 4'd11};
      default: r = 5'd0;
    endcase
    return r;
  endfunction

  function automatic logic [3:0] castle_lookup(input logic [7:0] c);
    logic [3:0] r;
    case (c)
      8'h4B:   r = CASTLE_WK;
      8'h51:   r = CASTLE_WQ;
      8'h6B:   r = CASTLE_BK;
      8'h71:   r = CASTLE_BQ;
      default: r = 4'd0;
    endcase
    return r;
  endfunction

  // v*10+d, saturating.
  function automatic logic [COUNTER_WIDTH-1:0] accumulate(
    input logic [COUNTER_WIDTH-1:0] v,
    input logic [3:0]               d
  );
    logic [COUNTER_WIDTH+3:0] n;
    logic [COUNTER_WIDTH+3:0] lim;
    n   = ({4'd0, v} << 3) + ({4'd0, v} << 1) + {{COUNTER_WIDTH{1'b0}}, d};
    lim = {4'd0, {COUNTER_WIDTH{1'b1}}};
    return (n > lim) ? {COUNTER_WIDTH{1'b1}} : n[COUNTER_WIDTH-1:0];
  endfunction

endpackage

// File: design/fpp_front.sv
// Front end: classifies each incoming character into a decoded word.
module fpp_front (
  input  logic             [7:0] char_code_i,
  input  logic                   last_char_i,
  output fpp_pkg::fpp_cls_t      cls_o
);
  import fpp_pkg::*;

  logic [4:0] pc_hit;
  logic [7:0] file_off;
  logic [7:0] digit_off;

  assign pc_hit    = piece_lookup(char_code_i);
  assign file_off  = char_code_i - CH_LC_A;
  assign digit_off = char_code_i - CH_ZERO;

  always_comb begin
    cls_o          = '0;
    cls_o.last     = last_char_i;
    cls_o.is_digit = (char_code_i >= CH_ZERO) && (char_code_i <= CH_NINE);
    cls_o.digit    = digit_off[3:0];
    cls_o.is_slash = (char_code_i == CH_SLASH);
    cls_o.is_space = (char_code_i == CH_SPACE);
    cls_o.is_dash  = (char_code_i == CH_DASH);
    cls_o.is_piece = pc_hit[4];
    cls_o.piece    = pc_hit[3:0];
    cls_o.castle   = castle_lookup(char_code_i);
    cls_o.is_file  = (char_code_i >= CH_LC_A) && (char_code_i <= CH_LC_H);
    cls_o.file     = file_off[2:0];
    cls_o.is_r3    = (char_code_i == CH_THREE);
    cls_o.is_r6    = (char_code_i == CH_SIX);
    cls_o.is_w     = (char_code_i == CH_LC_W);
    cls_o.is_b     = (char_code_i == CH_LC_B);
  end

endmodule

// File: design/fpp_queue.sv
// Short word queue between the classifier and the execution stage.
module fpp_queue (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  fpp_pkg::fpp_cls_t wdata_i,
  output logic              full_o,
  input  logic              pop_i,
  output logic              empty_o,
  output fpp_pkg::fpp_cls_t rdata_o
);
  import fpp_pkg::*;

  fpp_cls_t         mem_q [QDEPTH];
  logic [QAW-1:0]   wr_ptr_q, wr_ptr_d;
  logic [QAW-1:0]   rd_ptr_q, rd_ptr_d;
  logic [QAW:0]     count_q, count_d;
  logic             do_push, do_pop;

  assign full_o  = (count_q == (QAW+1)'(QDEPTH));
  assign empty_o = (count_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign rdata_o = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == QAW'(QDEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == QAW'(QDEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    case ({do_push, do_pop})
      2'b10:   count_d = count_q + 1'b1;
      2'b01:   count_d = count_q - 1'b1;
      default: count_d = count_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= wdata_i;
    end
  end

endmodule

// File: design/fpp_back.sv
// Back end: parser state machine and registered result word.
module fpp_back (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cls_valid_i,
  input  fpp_pkg::fpp_cls_t cls_i,
  output logic              cls_ready_o,
  output logic              res_valid_o,
  input  logic              res_ready_i,
  output fpp_pkg::fpp_res_t res_o
);
  import fpp_pkg::*;

  fpp_phase_e               phase_q, phase_d;
  logic [2:0]               rank_q, rank_d;
  logic [3:0]               file_q, file_d;
  logic                     side_q, side_d;
  logic [3:0]               castle_q, castle_d;
  logic                     ep_vld_q, ep_vld_d;
  logic [5:0]               ep_sq_q, ep_sq_d;
  logic [2:0]               ep_file_q, ep_file_d;
  logic [COUNTER_WIDTH-1:0] half_q, half_d;
  logic [COUNTER_WIDTH-1:0] full_q, full_d;
  logic                     dseen_q, dseen_d;
  logic                     err_q, err_d;
  logic                     out_vld_q;
  fpp_res_t                 res_q, res_d;
  logic                     step;
  logic                     err;
  logic                     done;
  logic                     placed;
  logic [4:0]               file_sum;

  assign cls_ready_o = !out_vld_q || res_ready_i;
  assign step        = cls_valid_i && cls_ready_o;
  assign res_valid_o = out_vld_q;
  assign res_o       = res_q;
  assign file_sum    = {1'b0, file_q} + {1'b0, cls_i.digit};

  always_comb begin
    phase_d   = phase_q;
    rank_d    = rank_q;
    file_d    = file_q;
    side_d    = side_q;
    castle_d  = castle_q;
    ep_vld_d  = ep_vld_q;
    ep_sq_d   = ep_sq_q;
    ep_file_d = ep_file_q;
    half_d    = half_q;
    full_d    = full_q;
    dseen_d   = dseen_q;
    err       = 1'b0;
    placed    = 1'b0;
    done      = 1'b0;
    res_d     = '0;

    if (!err_q) begin
      case (phase_q)
        PH_BOARD: begin
          if (cls_i.is_slash) begin
            if (file_q != 4'(BOARD_DIM) || rank_q == '0) err = 1'b1;
            else begin
              rank_d = rank_q - 1'b1;
              file_d = '0;
            end
          end else if (cls_i.is_space) begin
            if (file_q != 4'(BOARD_DIM) || rank_q != '0) err = 1'b1;
            else phase_d = PH_SIDE;
          end else if (cls_i.is_digit) begin
            if (cls_i.digit == '0 || file_sum > 5'(BOARD_DIM)) err = 1'b1;
            else file_d = file_sum[3:0];
          end else if (!cls_i.is_piece || file_q >= 4'(BOARD_DIM)) begin
            err = 1'b1;
          end else begin
            placed = 1'b1;
            file_d = file_q + 1'b1;
          end
        end
        PH_SIDE: begin
          if (cls_i.is_w) begin
            side_d  = 1'b0;
            phase_d = PH_SIDE_SP;
          end else if (cls_i.is_b) begin
            side_d  = 1'b1;
            phase_d = PH_SIDE_SP;
          end else err = 1'b1;
        end
        PH_SIDE_SP: begin
          if (cls_i.is_space) phase_d = PH_CAST_FIRST;
          else err = 1'b1;
        end
        PH_CAST_FIRST: begin
          if (cls_i.is_dash) begin
            castle_d = '0;
            phase_d  = PH_CAST_SP;
          end else if (cls_i.castle != '0) begin
            castle_d = castle_q | cls_i.castle;
            phase_d  = PH_CAST_MORE;
          end else err = 1'b1;
        end
        PH_CAST_MORE: begin
          if (cls_i.is_space) phase_d = PH_EP_FIRST;
          else if (cls_i.castle != '0) castle_d = castle_q | cls_i.castle;
          else err = 1'b1;
        end
        PH_CAST_SP: begin
          if (cls_i.is_space) phase_d = PH_EP_FIRST;
          else err = 1'b1;
        end
        PH_EP_FIRST: begin
          if (cls_i.is_dash) begin
            ep_vld_d = 1'b0;
            ep_sq_d  = '0;
            phase_d  = PH_EP_SP;
          end else if (cls_i.is_file) begin
            ep_file_d = cls_i.file;
            phase_d   = PH_EP_RANK;
          end else err = 1'b1;
        end
        PH_EP_RANK: begin
          if (cls_i.is_r3 || cls_i.is_r6) begin
            ep_vld_d = 1'b1;
            ep_sq_d  = {(cls_i.is_r6 ? 3'd5 : 3'd2), ep_file_q};
            phase_d  = PH_EP_SP;
          end else err = 1'b1;
        end
        PH_EP_SP: begin
          if (cls_i.is_space) begin
            phase_d = PH_HALF;
            dseen_d = 1'b0;
          end else err = 1'b1;
        end
        PH_HALF: begin
          if (cls_i.is_digit) begin
            half_d  = accumulate(half_q, cls_i.digit);
            dseen_d = 1'b1;
          end else if (cls_i.is_space && dseen_q) begin
            phase_d = PH_FULL;
            dseen_d = 1'b0;
          end else err = 1'b1;
        end
        PH_FULL: begin
          if (cls_i.is_digit) begin
            full_d  = accumulate(full_q, cls_i.digit);
            dseen_d = 1'b1;
          end else err = 1'b1;
        end
        default: err = 1'b1;
      endcase
    end

    err_d = err_q || err;
    if (cls_i.last && !err_d) begin
      if (phase_d == PH_FULL && dseen_d && full_d != '0) done = 1'b1;
      else err_d = 1'b1;
    end

    res_d.place_valid    = placed && !err_d;
    res_d.square         = (placed && !err_d) ? {rank_q, file_q[2:0]} : '0;
    res_d.piece          = (placed && !err_d) ? cls_i.piece : '0;
    res_d.done_res       = done;
    res_d.error          = err_d;
    res_d.turn           = side_d;
    res_d.castle_rights  = castle_d;
    res_d.ep_present     = ep_vld_d;
    res_d.ep_square      = ep_sq_d;
    res_d.halfmove_count = CNT_OUT_W'(half_d);
    res_d.fullmove_count = CNT_OUT_W'(full_d);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= PH_BOARD;
      rank_q    <= 3'(BOARD_DIM - 1);
      file_q    <= '0;
      side_q    <= 1'b0;
      castle_q  <= '0;
      ep_vld_q  <= 1'b0;
      ep_sq_q   <= '0;
      ep_file_q <= '0;
      half_q    <= '0;
      full_q    <= '0;
      dseen_q   <= 1'b0;
      err_q     <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      if (step) begin
        out_vld_q <= 1'b1;
      end else if (res_ready_i) begin
        out_vld_q <= 1'b0;
      end
      if (step && cls_i.last) begin
        phase_q   <= PH_BOARD;
        rank_q    <= 3'(BOARD_DIM - 1);
        file_q    <= '0;
        side_q    <= 1'b0;
        castle_q  <= '0;
        ep_vld_q  <= 1'b0;
        ep_sq_q   <= '0;
        ep_file_q <= '0;
        half_q    <= '0;
        full_q    <= '0;
        dseen_q   <= 1'b0;
        err_q     <= 1'b0;
      end else if (step) begin
        phase_q   <= phase_d;
        rank_q    <= rank_d;
        file_q    <= file_d;
        side_q    <= side_d;
        castle_q  <= castle_d;
        ep_vld_q  <= ep_vld_d;
        ep_sq_q   <= ep_sq_d;
        ep_file_q <= ep_file_d;
        half_q    <= half_d;
        full_q    <= full_d;
        dseen_q   <= dseen_d;
        err_q     <= err_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (step) begin
      res_q <= res_d;
    end
  end

endmodule

// File: design/fen_position_parser.sv
// Top level of the FEN position parser: classifier, word queue and parser back end.
//   channel | direction | handshake           | word
//   in      | input     | in_valid_i/ready_o  | char_code_i, last_char_i
//   out     | output    | out_valid_o/ready_i | place_valid_o .. fullmove_count_o
// One character per cycle sustained while out_ready_i holds; each word is one result word.
// A character's result word is registered twice, first in a queue entry and then in the
// result register; a stalled output can hold it in the queue.
// The two-entry queue and the result register let either side stall independently.
// Reset returns the parser to the start of the board section; the final character
// of each string does the same after its result is formed.
module fen_position_parser (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [7:0]  char_code_i,
  input  logic        last_char_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic        place_valid_o,
  output logic [5:0]  square_o,
  output logic [3:0]  piece_o,
  output logic        done_res_o,
  output logic        error_o,
  output logic        turn_o,
  output logic [3:0]  castle_rights_o,
  output logic        ep_present_o,
  output logic [5:0]  ep_square_o,
  output logic [15:0] halfmove_count_o,
  output logic [15:0] fullmove_count_o
);
  import fpp_pkg::*;

  fpp_cls_t cls_in;
  fpp_cls_t cls_out;
  fpp_res_t res;
  logic     q_full;
  logic     q_empty;
  logic     back_ready;

  assign in_ready_o = !q_full;

  fpp_front u_front (
    .char_code_i (char_code_i),
    .last_char_i (last_char_i),
    .cls_o       (cls_in)
  );

  fpp_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (in_valid_i),
    .wdata_i (cls_in),
    .full_o  (q_full),
    .pop_i   (back_ready),
    .empty_o (q_empty),
    .rdata_o (cls_out)
  );

  fpp_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cls_valid_i (!q_empty),
    .cls_i       (cls_out),
    .cls_ready_o (back_ready),
    .res_valid_o (out_valid_o),
    .res_ready_i (out_ready_i),
    .res_o       (res)
  );

  assign place_valid_o    = res.place_valid;
  assign square_o         = res.square;
  assign piece_o          = res.piece;
  assign done_res_o       = res.done_res;
  assign error_o          = res.error;
  assign turn_o           = res.turn;
  assign castle_rights_o  = res.castle_rights;
  assign ep_present_o     = res.ep_present;
  assign ep_square_o      = res.ep_square;
  assign halfmove_count_o = 16'(res.halfmove_count);
  assign fullmove_count_o = 16'(res.fullmove_count);

endmodule

// File: design/fpp_checker.sv
// Port-level checks on the FEN parser and their bind to the top level.
module fpp_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        out_valid_o,
  input logic        out_ready_i,
  input logic        place_valid_o,
  input logic [3:0]  piece_o,
  input logic        done_res_o,
  input logic        error_o,
  input logic [15:0] fullmove_count_o
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o)
    else $error("result word dropped while stalled");

  a_done_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && done_res_o |-> !error_o)
    else $error("done flagged with error");

  a_place_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && place_valid_o |-> !error_o && piece_o < 4'd12)
    else $error("bad piece placement word");

  a_done_fullmove: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && done_res_o |-> fullmove_count_o != 16'd0)
    else $error("done with zero fullmove number");

endmodule

bind fen_position_parser fpp_checker u_fpp_checker (
  .clk_i            (clk_i),
  .rst_ni           (rst_ni),
  .out_valid_o      (out_valid_o),
  .out_ready_i      (out_ready_i),
  .place_valid_o    (place_valid_o),
  .piece_o          (piece_o),
  .done_res_o       (done_res_o),
  .error_o          (error_o),
  .fullmove_count_o (fullmove_count_o)
);
